// File: design/wsnfd_pkg.sv
// Shared types, constants and helpers for the nibble frame decoder.
`default_nettype none
package wsnfd_pkg;

	localparam int MAX_NIBBLES = 16;
	localparam int NIB_W       = 4;
	localparam int IDX_W       = $clog2(MAX_NIBBLES);
	localparam int BIT_CNT_W   = 5;
	// Nibbles carried to the field decoder: the type and data nibbles 1 to 13
	localparam int FRAME_NIBS  = 14;
	localparam int QUEUE_DEPTH = 2;

	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_IDX_W   = CFG_ADDR_W - 2;

	localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE   = CFG_IDX_W'(0);
	localparam logic [BIT_CNT_W-1:0] PREAMBLE_RESET = BIT_CNT_W'(11);

	localparam logic [NIB_W-1:0] SUM_BIAS      = NIB_W'(5);
	localparam logic [10:0]      PRESSURE_BASE = 11'd200;
	localparam logic [NIB_W-1:0] TYPE_BARO     = NIB_W'(4);
	localparam logic [NIB_W-1:0] TYPE_WIND     = NIB_W'(7);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PRE,
		PH_NIB,
		PH_STOP,
		PH_SUM
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_STOP = 2'd1,
		ST_XOR  = 2'd2,
		ST_SUM  = 2'd3
	} stat_t;

	typedef logic [NIB_W-1:0] nib_t;

	typedef struct packed {
		stat_t                       status;
		logic                        full;
		logic [FRAME_NIBS-1:0][NIB_W-1:0] nib;
	} frame_t;

	// Index of the last data nibble (the check nibble) for each sensor type
	function automatic logic [IDX_W-1:0] data_len(input nib_t kind);
		logic [IDX_W-1:0] len;
		unique case (kind)
			4'd0:    len = IDX_W'(5);
			4'd1:    len = IDX_W'(8);
			4'd2:    len = IDX_W'(5);
			4'd3:    len = IDX_W'(8);
			4'd4:    len = IDX_W'(12);
			4'd5:    len = IDX_W'(9);
			4'd6:    len = IDX_W'(8);
			4'd7:    len = IDX_W'(14);
			4'd8:    len = IDX_W'(8);
			default: len = IDX_W'(0);
		endcase
		return len;
	endfunction

	// Three BCD-style digits to binary: h*100 + t*10 + u
	function automatic logic [10:0] bcd3(input nib_t h, input nib_t t, input nib_t u);
		logic [10:0] acc;
		acc = 11'({7'd0, h} * 11'd100) + 11'({7'd0, t} * 11'd10) + {7'd0, u};
		return acc;
	endfunction

endpackage
`default_nettype wire

// File: design/wsnfd_if.sv
// Channel interfaces: bit stream in, decoded frame reports out.
`default_nettype none
interface wsnfd_bit_if;
	logic valid;
	logic ready;
	logic bit_value;
	logic frame_start;

	modport source(output valid, output bit_value, output frame_start, input ready);
	modport sink(input valid, input bit_value, input frame_start, output ready);
endinterface

interface wsnfd_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [3:0]         sensor_type;
	logic [2:0]         sensor_id;
	logic signed [11:0] temp_tenths;
	logic [10:0]        humidity_tenths;
	logic [10:0]        baro_hpa;
	logic [10:0]        wind_tenths;
	logic [11:0]        rain_ticks;
	logic               rain_flag;
	logic [3:0]         unknown_nibble;

	modport source(output valid, output status, output sensor_type, output sensor_id,
		output temp_tenths, output humidity_tenths, output baro_hpa,
		output wind_tenths, output rain_ticks, output rain_flag, output unknown_nibble,
		input ready);
	modport sink(input valid, input status, input sensor_type, input sensor_id,
		input temp_tenths, input humidity_tenths, input baro_hpa,
		input wind_tenths, input rain_ticks, input rain_flag, input unknown_nibble,
		output ready);
endinterface
`default_nettype wire

// File: design/wsnfd_front.sv
// Front end: frame tracking, nibble collection and check accumulation.
`default_nettype none
module wsnfd_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	wsnfd_bit_if.sink                          sample,
	input  wire logic [wsnfd_pkg::BIT_CNT_W-1:0] preamble,
	input  wire logic                          q_full,
	output      logic                          push,
	output      wsnfd_pkg::frame_t             entry
);

	wsnfd_pkg::phase_t phase_q, phase_d, ph_e;

	logic [wsnfd_pkg::BIT_CNT_W-1:0] bc_q, bc_d, bc_e, bc_b;
	wsnfd_pkg::nib_t                 sh_q, sh_d, sh_e, sh_b, sh_new;
	logic [wsnfd_pkg::IDX_W-1:0]     idx_q, idx_d, idx_e;
	wsnfd_pkg::nib_t                 xor_q, xor_d, xor_n;
	wsnfd_pkg::nib_t                 sum_q, sum_d, sum_n;
	wsnfd_pkg::nib_t                 store_q [wsnfd_pkg::MAX_NIBBLES];

	logic acc, clear, wr_en;
	logic in_pre, skip, shift_mode, in_sum, in_stop, nib_full, last, sum_ok;
	logic fin_sum, fin_stop, fin_xor;

	assign sample.ready = !q_full;
	assign acc   = sample.valid && sample.ready;
	assign clear = acc && sample.frame_start;

	// A frame start restarts decoding on this very bit
	assign ph_e  = sample.frame_start ? wsnfd_pkg::PH_PRE : phase_q;
	assign bc_e  = sample.frame_start ? '0 : bc_q;
	assign sh_e  = sample.frame_start ? '0 : sh_q;
	assign idx_e = sample.frame_start ? '0 : idx_q;

	assign in_pre     = (ph_e == wsnfd_pkg::PH_PRE);
	assign skip       = in_pre && (bc_e < preamble);
	assign in_sum     = (ph_e == wsnfd_pkg::PH_SUM);
	assign in_stop    = (ph_e == wsnfd_pkg::PH_STOP);
	assign shift_mode = (in_pre && !skip) || (ph_e == wsnfd_pkg::PH_NIB) || in_sum;

	assign bc_b     = in_pre ? '0 : bc_e;
	assign sh_b     = in_pre ? '0 : sh_e;
	assign sh_new   = sh_b | (wsnfd_pkg::nib_t'(sample.bit_value) << bc_b[1:0]);
	assign nib_full = (bc_b[1:0] == 2'd3);
	assign sum_ok   = (sh_new == wsnfd_pkg::nib_t'(sum_q + wsnfd_pkg::SUM_BIAS));

	// The last collected nibble still sits in the shift register during the stop bit
	assign xor_n = xor_q ^ sh_q;
	assign sum_n = wsnfd_pkg::nib_t'(sum_q + sh_q);
	assign last  = (idx_q >= wsnfd_pkg::data_len(store_q[0]));

	assign fin_sum  = in_sum && nib_full;
	assign fin_stop = in_stop && !sample.bit_value;
	assign fin_xor  = in_stop && sample.bit_value && last && (xor_n != '0);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (acc) begin
			unique case (ph_e)
				wsnfd_pkg::PH_IDLE: phase_d = wsnfd_pkg::PH_IDLE;
				wsnfd_pkg::PH_PRE:  phase_d = skip ? wsnfd_pkg::PH_PRE : wsnfd_pkg::PH_NIB;
				wsnfd_pkg::PH_NIB:  phase_d = nib_full ? wsnfd_pkg::PH_STOP : wsnfd_pkg::PH_NIB;
				wsnfd_pkg::PH_SUM:  phase_d = nib_full ? wsnfd_pkg::PH_IDLE : wsnfd_pkg::PH_SUM;
				wsnfd_pkg::PH_STOP: begin
					if (!sample.bit_value)
						phase_d = wsnfd_pkg::PH_IDLE;
					else if (last)
						phase_d = (xor_n != '0) ? wsnfd_pkg::PH_IDLE : wsnfd_pkg::PH_SUM;
					else
						phase_d = wsnfd_pkg::PH_NIB;
				end
				default: phase_d = wsnfd_pkg::PH_IDLE;
			endcase
		end
	end

	// Counters, accumulators and the result transfer
	always_comb begin
		bc_d  = bc_q;
		sh_d  = sh_q;
		idx_d = idx_q;
		xor_d = xor_q;
		sum_d = sum_q;
		wr_en = 1'b0;
		if (acc) begin
			bc_d  = bc_e;
			sh_d  = sh_e;
			idx_d = idx_e;
			xor_d = sample.frame_start ? '0 : xor_q;
			sum_d = sample.frame_start ? '0 : sum_q;
			priority if (skip) begin
				bc_d = bc_e + 1'b1;
			end else if (shift_mode) begin
				sh_d  = sh_new;
				bc_d  = nib_full ? '0 : bc_b + 1'b1;
				wr_en = nib_full && !in_sum;
			end else if (in_stop) begin
				xor_d = xor_n;
				sum_d = sum_n;
				bc_d  = '0;
				sh_d  = '0;
				if (sample.bit_value && !last)
					idx_d = idx_q + 1'b1;
			end else begin
				bc_d = bc_e;
			end
		end
	end

	assign push = acc && (fin_sum || fin_stop || fin_xor);

	always_comb begin
		if (fin_sum)
			entry.status = sum_ok ? wsnfd_pkg::ST_OK : wsnfd_pkg::ST_SUM;
		else if (fin_stop)
			entry.status = wsnfd_pkg::ST_STOP;
		else
			entry.status = wsnfd_pkg::ST_XOR;
		entry.full = fin_sum && sum_ok;
		for (int i = 0; i < wsnfd_pkg::FRAME_NIBS; i++)
			entry.nib[i] = store_q[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wsnfd_pkg::PH_IDLE;
			bc_q    <= '0;
			sh_q    <= '0;
			idx_q   <= '0;
			xor_q   <= '0;
			sum_q   <= '0;
		end else begin
			phase_q <= phase_d;
			bc_q    <= bc_d;
			sh_q    <= sh_d;
			idx_q   <= idx_d;
			xor_q   <= xor_d;
			sum_q   <= sum_d;
		end
	end

	// Nibble store: cleared at every frame start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wsnfd_pkg::MAX_NIBBLES; i++)
				store_q[i] <= '0;
		end else begin
			if (clear) begin
				for (int i = 0; i < wsnfd_pkg::MAX_NIBBLES; i++)
					store_q[i] <= '0;
			end
			if (wr_en)
				store_q[idx_e] <= sh_new;
		end
	end

	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> phase_q != wsnfd_pkg::PH_IDLE)
		else $error("frame start did not open a frame");

	a_push_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> phase_q == wsnfd_pkg::PH_IDLE)
		else $error("frame still open after its result");

endmodule
`default_nettype wire

// File: design/wsnfd_fifo.sv
// Short queue of finished frames between the front end and the field decoder.
`default_nettype none
module wsnfd_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire wsnfd_pkg::frame_t wdata,
	output      logic              full,
	input  wire logic              pop,
	output      logic              not_empty,
	output      wsnfd_pkg::frame_t rdata
);

	localparam int PTR_W = (wsnfd_pkg::QUEUE_DEPTH > 1) ? $clog2(wsnfd_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(wsnfd_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(wsnfd_pkg::QUEUE_DEPTH - 1);

	wsnfd_pkg::frame_t mem [wsnfd_pkg::QUEUE_DEPTH];

	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full      = (count_q == CNT_W'(wsnfd_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rdata     = mem[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(wsnfd_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule
`default_nettype wire

// File: design/wsnfd_back.sv
// Back end: turns a queued frame into its report fields and holds the output register.
`default_nettype none
module wsnfd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  wire wsnfd_pkg::frame_t head,
	output      logic              pop,
	wsnfd_res_if.source            report
);

	wsnfd_pkg::nib_t kind;
	logic [10:0]     mag, hum, pres, wind;
	logic [11:0]     temp, rain;
	logic            load;

	logic               valid_q;
	logic [1:0]         status_q;
	logic [3:0]         type_q;
	logic [2:0]         id_q;
	logic signed [11:0] temp_q;
	logic [10:0]        hum_q, pres_q, wind_q;
	logic [11:0]        rain_q;
	logic               raining_q;
	logic [3:0]         unk_q;

	assign kind = head.nib[0];
	assign load = head_valid && (!valid_q || report.ready);
	assign pop  = load;

	always_comb begin
		mag  = wsnfd_pkg::bcd3(head.nib[4], head.nib[3], head.nib[2]);
		// Negative when bit 3 of the id nibble is set
		temp = head.nib[1][3] ? 12'(-{1'b0, mag}) : {1'b0, mag};
		if (kind == wsnfd_pkg::TYPE_WIND)
			hum = wsnfd_pkg::bcd3(head.nib[6], head.nib[5], '0);
		else
			hum = wsnfd_pkg::bcd3(head.nib[7], head.nib[6], head.nib[5]);
		pres = (kind == wsnfd_pkg::TYPE_BARO)
			? wsnfd_pkg::PRESSURE_BASE + wsnfd_pkg::bcd3(head.nib[10], head.nib[9], head.nib[8])
			: '0;
		wind = (kind == wsnfd_pkg::TYPE_WIND)
			? wsnfd_pkg::bcd3(head.nib[9], head.nib[8], head.nib[7]) : '0;
		rain = (kind == wsnfd_pkg::TYPE_WIND)
			? {head.nib[12], head.nib[11], head.nib[10]} : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (report.ready)
			valid_q <= 1'b0;
	end

	// Failed frames carry only status and type
	always_ff @(posedge clk) begin
		if (load) begin
			status_q  <= head.status;
			type_q    <= kind;
			id_q      <= head.full ? head.nib[1][2:0] : '0;
			temp_q    <= head.full ? temp : '0;
			hum_q     <= head.full ? hum : '0;
			pres_q    <= head.full ? pres : '0;
			wind_q    <= head.full ? wind : '0;
			rain_q    <= head.full ? rain : '0;
			raining_q <= head.full && (kind == wsnfd_pkg::TYPE_WIND) && head.nib[1][1];
			unk_q     <= (head.full && (kind == wsnfd_pkg::TYPE_WIND)) ? head.nib[13] : '0;
		end
	end

	assign report.valid           = valid_q;
	assign report.status          = status_q;
	assign report.sensor_type     = type_q;
	assign report.sensor_id       = id_q;
	assign report.temp_tenths     = temp_q;
	assign report.humidity_tenths = hum_q;
	assign report.baro_hpa        = pres_q;
	assign report.wind_tenths     = wind_q;
	assign report.rain_ticks      = rain_q;
	assign report.rain_flag       = raining_q;
	assign report.unknown_nibble  = unk_q;

	a_error_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && (status_q != wsnfd_pkg::ST_OK) |->
			(temp_q == '0) && (hum_q == '0) && (pres_q == '0) && (rain_q == '0) && !raining_q)
		else $error("failed frame reported with data fields");

endmodule
`default_nettype wire

// File: design/weather_sensor_nibble_frame_decoder.sv
// Top level of the nibble frame decoder: register port, front end, queue and field decoder.
// Takes one bit per cycle unless stalled; a frame report is queued, then registered.
// The bit input stalls only while the two-entry frame queue is full behind a held report.
// Asynchronous active-low reset: decoder idle, nibble store cleared, preamble length 11.
`default_nettype none
module weather_sensor_nibble_frame_decoder (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	wsnfd_bit_if.sink                             sample,
	wsnfd_res_if.source                           report,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [wsnfd_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [wsnfd_pkg::CFG_DATA_W-1:0] pwdata,
	output      logic [wsnfd_pkg::CFG_DATA_W-1:0] prdata,
	output      logic                             pready
);

	logic [wsnfd_pkg::BIT_CNT_W-1:0] preamble_q;
	logic [wsnfd_pkg::CFG_IDX_W-1:0] reg_idx;
	logic                            q_full, push, pop, q_valid;
	wsnfd_pkg::frame_t               entry, head;

	assign pready  = 1'b1;
	assign reg_idx = paddr[wsnfd_pkg::CFG_ADDR_W-1:2];

	always_comb begin
		if (reg_idx == wsnfd_pkg::REG_PREAMBLE)
			prdata = wsnfd_pkg::CFG_DATA_W'(preamble_q);
		else
			prdata = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			preamble_q <= wsnfd_pkg::PREAMBLE_RESET;
		else if (psel && penable && pwrite && pready && (reg_idx == wsnfd_pkg::REG_PREAMBLE))
			preamble_q <= pwdata[wsnfd_pkg::BIT_CNT_W-1:0];
	end

	wsnfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample),
		.preamble (preamble_q),
		.q_full   (q_full),
		.push     (push),
		.entry    (entry)
	);

	wsnfd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (entry),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.rdata     (head)
	);

	wsnfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head       (head),
		.pop        (pop),
		.report     (report)
	);

endmodule
`default_nettype wire
